// ----- rtl/integral_image_stream_assert.svh -----
// Assertion macros used by the integral image stream RTL.
`ifndef INTEGRAL_IMAGE_STREAM_ASSERT_SVH
`define INTEGRAL_IMAGE_STREAM_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define IIS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("integral image assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define IIS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("integral image assertion failed");

`endif

// ----- rtl/iis_pkg.sv -----
package iis_pkg;

    // Default sizes of the block.
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_PIXEL_BITS = 16;

    // Configuration port.
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 11;

    localparam logic [CFG_DATA_BITS-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [CFG_DATA_BITS-1:0] RST_FRAME_HEIGHT = 11'd480;

    // Register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    // Position flags that travel with a pixel from the counters to the adder stage.
    typedef struct packed {
        logic first_row;
        logic eor;
        logic eof;
    } t_pix_tag;

endpackage

// ----- rtl/iis_ctrl.sv -----
module iis_ctrl #(
    parameter int MAX_WIDTH  = iis_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = iis_pkg::DEF_MAX_HEIGHT,
    parameter int COL_BITS   = 10
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [iis_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [iis_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                             i_accept,
    output logic [COL_BITS-1:0]              o_col,
    output iis_pkg::t_pix_tag                o_tag
);
    import iis_pkg::*;

    localparam int ROW_BITS = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [CFG_DATA_BITS-1:0] r_frame_width;
    logic [CFG_DATA_BITS-1:0] r_frame_height;
    logic [COL_BITS-1:0]      r_col;
    logic [ROW_BITS-1:0]      r_row;

    logic [31:0]         w_ext, h_ext, w_tmp, h_tmp;
    logic [COL_BITS:0]   w_eff, col_inc;
    logic [ROW_BITS:0]   h_eff, row_inc;
    logic                eor, eof;

    // Configuration registers take every write transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
            endcase
        end
    end

    // Effective frame size: zero counts as one, large values saturate.
    always_comb begin
        w_ext = 32'(r_frame_width);
        h_ext = 32'(r_frame_height);
        if (w_ext == 32'd0)                w_tmp = 32'd1;
        else if (w_ext > 32'(MAX_WIDTH))   w_tmp = 32'(MAX_WIDTH);
        else                               w_tmp = w_ext;
        if (h_ext == 32'd0)                h_tmp = 32'd1;
        else if (h_ext > 32'(MAX_HEIGHT))  h_tmp = 32'(MAX_HEIGHT);
        else                               h_tmp = h_ext;
        w_eff = w_tmp[COL_BITS:0];
        h_eff = h_tmp[ROW_BITS:0];
    end

    // Row and frame ends seen from the current position.
    assign col_inc = {1'b0, r_col} + 1'b1;
    assign row_inc = {1'b0, r_row} + 1'b1;
    assign eor     = (col_inc >= w_eff);
    assign eof     = eor && (row_inc >= h_eff);

    // Raster position advances on every input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            if (eor) begin
                r_col <= '0;
                r_row <= eof ? '0 : row_inc[ROW_BITS-1:0];
            end else begin
                r_col <= col_inc[COL_BITS-1:0];
            end
        end
    end

    assign o_col           = r_col;
    assign o_tag.first_row = (r_row == '0);
    assign o_tag.eor       = eor;
    assign o_tag.eof       = eof;

endmodule

// ----- rtl/iis_colmem.sv -----
module iis_colmem #(
    parameter int DEPTH     = iis_pkg::DEF_MAX_WIDTH,
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 26
) (
    input  logic                 i_clk,
    input  logic                 i_rd_en,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic [DATA_BITS-1:0] o_rd_data,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [DATA_BITS-1:0] i_wr_data
);
    import iis_pkg::*;

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [DATA_BITS-1:0] r_rd_data;

    // Column sum store: one write port, one registered read port.
    // The read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/iis_accum.sv -----
module iis_accum #(
    parameter int PIXEL_BITS  = iis_pkg::DEF_PIXEL_BITS,
    parameter int COL_BITS    = 10,
    parameter int COLSUM_BITS = 26,
    parameter int AREA_BITS   = 36
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [PIXEL_BITS-1:0]  i_pixel,
    input  iis_pkg::t_pix_tag      i_tag,
    input  logic [COL_BITS-1:0]    i_col,
    input  logic [COLSUM_BITS-1:0] i_rd_data,
    output logic                   o_wr_en,
    output logic [COL_BITS-1:0]    o_wr_addr,
    output logic [COLSUM_BITS-1:0] o_wr_data,
    output logic                   o_in_ready,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [AREA_BITS-1:0]   o_area_sum,
    output logic                   o_end_of_row,
    output logic                   o_end_of_frame
);
    import iis_pkg::*;
    `include "integral_image_stream_assert.svh"

    logic                   r_s1_valid;
    t_pix_tag               r_tag;
    logic [PIXEL_BITS-1:0]  r_pix;
    logic [COL_BITS-1:0]    r_col;
    logic                   r_fwd_hit;
    logic [COLSUM_BITS-1:0] r_fwd_data;
    logic                   r_unwritten;
    logic [COL_BITS:0]      r_fill;
    logic [AREA_BITS-1:0]   r_row_sum;
    logic                   r_o_valid;
    logic [AREA_BITS-1:0]   r_o_area;
    logic                   r_o_eor;
    logic                   r_o_eof;

    logic                   out_free, s1_adv;
    logic [COLSUM_BITS-1:0] col_old, colsum;
    logic [AREA_BITS-1:0]   area;

    // Stage one moves on when the output register is empty or being taken.
    assign out_free   = !r_o_valid || i_out_ready;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_ready = i_rst_n && (!r_s1_valid || s1_adv);

    // Read-modify-write of the column sum, with forwarding of a write that
    // lands in the same cycle as the read of the same column. A column not
    // written since reset reads as zero.
    assign col_old = r_fwd_hit   ? r_fwd_data :
                     r_unwritten ? '0 : i_rd_data;
    assign colsum  = r_tag.first_row ? COLSUM_BITS'(r_pix)
                                     : col_old + COLSUM_BITS'(r_pix);
    assign area    = r_row_sum + AREA_BITS'(colsum);

    assign o_wr_en   = s1_adv;
    assign o_wr_addr = r_col;
    assign o_wr_data = colsum;

    // Stage one holds the pixel while its column sum is read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else if (i_accept) begin
            r_s1_valid <= 1'b1;
            r_fwd_hit  <= s1_adv && (i_col == r_col);
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_tag       <= i_tag;
            r_pix       <= i_pixel;
            r_col       <= i_col;
            r_fwd_data  <= colsum;
            r_unwritten <= ({1'b0, i_col} >= r_fill);
        end
    end

    // Columns are written in order from the left edge, so the store holds
    // valid sums for every column below this count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (s1_adv && ({1'b0, r_col} >= r_fill)) begin
            r_fill <= {1'b0, r_col} + 1'b1;
        end
    end

    // Running sum across the current row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_sum <= '0;
        end else if (s1_adv) begin
            r_row_sum <= r_tag.eor ? '0 : area;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_area <= area;
            r_o_eor  <= r_tag.eor;
            r_o_eof  <= r_tag.eof;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_area_sum     = r_o_area;
    assign o_end_of_row   = r_o_eor;
    assign o_end_of_frame = r_o_eof;

    // A stalled stage-one item is kept, not dropped.
    `IIS_ASSERT_NEXT(a_s1_kept, i_clk, i_rst_n, r_s1_valid && !out_free, r_s1_valid)
    // A read of the column being written in the same cycle takes the new sum.
    `IIS_ASSERT_NEXT(a_fwd_src, i_clk, i_rst_n, i_accept && s1_adv && (i_col == r_col), r_fwd_hit && (r_fwd_data == $past(colsum)))
    // The row sum restarts after the last pixel of a row.
    `IIS_ASSERT_NEXT(a_row_clr, i_clk, i_rst_n, s1_adv && r_tag.eor, r_row_sum == '0)
    // The end of a frame is always also the end of a row.
    `IIS_ASSERT_NOW(a_eof_eor, i_clk, i_rst_n, r_o_valid && r_o_eof, r_o_eor)

endmodule

// ----- rtl/integral_image_stream.sv -----
// Channel   | Handshake              | Payload
// ----------+------------------------+-------------------------------------------
// input     | i_valid / o_ready      | i_pixel_value
// output    | o_valid / i_ready      | o_area_sum, o_end_of_row, o_end_of_frame
// config    | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One pixel is taken per cycle unless the output stalls; results are registered.
// The rate is set by the column-sum read-modify-write: read at the input
// transfer, add and write as stage one advances, forwarded when the next pixel
// reads the same column. Reset is synchronous and active low and clears the
// positions, the row sum and a count of written columns; the column store needs
// no clearing since columns not yet written since reset read as zero.
// An output stall holds the output register and
// the pixel in the adder stage, and input is taken again once that stage frees.
module integral_image_stream #(
    parameter int MAX_WIDTH  = iis_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = iis_pkg::DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = iis_pkg::DEF_PIXEL_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [PIXEL_BITS-1:0]                 i_pixel_value,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [PIXEL_BITS + $clog2(MAX_HEIGHT) + $clog2(MAX_WIDTH)-1:0] o_area_sum,
    output logic                                  o_end_of_row,
    output logic                                  o_end_of_frame,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [iis_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [iis_pkg::CFG_DATA_BITS-1:0]      i_cfg_data
);
    import iis_pkg::*;

    localparam int COL_BITS    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int COLSUM_BITS = PIXEL_BITS + $clog2(MAX_HEIGHT);
    localparam int AREA_BITS   = COLSUM_BITS + $clog2(MAX_WIDTH);

    logic                   accept, in_ready, cfg_write;
    logic [COL_BITS-1:0]    col;
    t_pix_tag               tag;
    logic [COLSUM_BITS-1:0] rd_data, wr_data;
    logic                   wr_en;
    logic [COL_BITS-1:0]    wr_addr;

    // Transfers on the input and configuration channels.
    assign o_ready     = in_ready;
    assign accept      = i_valid && in_ready;
    assign o_cfg_ready = i_rst_n;
    assign cfg_write   = i_cfg_valid && i_rst_n;

    iis_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COL_BITS   (COL_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_write),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .o_col       (col),
        .o_tag       (tag)
    );

    iis_colmem #(
        .DEPTH     (MAX_WIDTH),
        .ADDR_BITS (COL_BITS),
        .DATA_BITS (COLSUM_BITS)
    ) u_colmem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (col),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    iis_accum #(
        .PIXEL_BITS  (PIXEL_BITS),
        .COL_BITS    (COL_BITS),
        .COLSUM_BITS (COLSUM_BITS),
        .AREA_BITS   (AREA_BITS)
    ) u_accum (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_pixel        (i_pixel_value),
        .i_tag          (tag),
        .i_col          (col),
        .i_rd_data      (rd_data),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data),
        .o_in_ready     (in_ready),
        .i_out_ready    (i_ready),
        .o_out_valid    (o_valid),
        .o_area_sum     (o_area_sum),
        .o_end_of_row   (o_end_of_row),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule

// ----- tb/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import iis_pkg::*;

    localparam int MAX_W = DEF_MAX_WIDTH;
    localparam int MAX_H = DEF_MAX_HEIGHT;
    localparam int PIX_W = DEF_PIXEL_BITS;
    localparam int SUM_W = PIX_W + $clog2(MAX_H) + $clog2(MAX_W);
    localparam int COL_W = PIX_W + $clog2(MAX_H);
    localparam int RANDOM_PIXELS = 600;

    typedef struct packed {
        logic [SUM_W-1:0] area;
        logic             eor;
        logic             eof;
    } area_result_t;

    // Ports of the block; the inputs are at known values from time zero.
    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic [PIX_W-1:0]         i_pixel_value = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic [SUM_W-1:0]         o_area_sum;
    logic                     o_end_of_row;
    logic                     o_end_of_frame;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = REG_FRAME_WIDTH;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    // Shadow of the block's registers and running sums.
    logic [CFG_DATA_BITS-1:0] size_width = RST_FRAME_WIDTH;
    logic [CFG_DATA_BITS-1:0] size_height = RST_FRAME_HEIGHT;
    logic [COL_W-1:0]         column_total [MAX_W];
    logic [SUM_W-1:0]         row_total = '0;
    logic [9:0]               column_at = '0;
    logic [9:0]               row_at = '0;
    int                       columns_filled = 0;
    area_result_t             area_expected [$];

    // Run control and statistics.
    int idle_pct = 7;
    int ready_hold = 0;
    int pixels_sent = 0;
    int sums_checked = 0;
    int frames_seen = 0;
    int mismatches = 0;

    integral_image_stream dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_pixel_value  (i_pixel_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_area_sum     (o_area_sum),
        .o_end_of_row   (o_end_of_row),
        .o_end_of_frame (o_end_of_frame),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("testbench: done, errors");
        $finish;
    end

    // A size of zero counts as one, and anything above the limit is saturated.
    function automatic int effective_size(logic [CFG_DATA_BITS-1:0] v, int limit);
        if (v == '0) return 1;
        if (int'(v) > limit) return limit;
        return int'(v);
    endfunction

    // Work out the summed-area value of one accepted pixel and queue it.
    function automatic void predict_area(logic [PIX_W-1:0] pix);
        int               w;
        int               h;
        int               c;
        logic [COL_W-1:0] column_sum;
        area_result_t     r;
        w = effective_size(size_width, MAX_W);
        h = effective_size(size_height, MAX_H);
        c = int'(column_at);
        // The first row of a frame ignores whatever the column store holds.
        if (row_at == '0) begin
            column_sum = COL_W'(pix);
        end else begin
            column_sum = column_total[c] + COL_W'(pix);
        end
        column_total[c] = column_sum;
        if (c + 1 > columns_filled) columns_filled = c + 1;
        row_total = row_total + SUM_W'(column_sum);
        r.area = row_total;
        r.eor = (c + 1 >= w);
        r.eof = r.eor && (int'(row_at) + 1 >= h);
        area_expected.push_back(r);
        if (r.eor) begin
            column_at = '0;
            row_total = '0;
            row_at = r.eof ? 10'd0 : row_at + 10'd1;
        end else begin
            column_at = column_at + 10'd1;
        end
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // Predict on every input transfer, then check every output transfer.
    always @(posedge i_clk) begin : scoreboard
        area_result_t want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                predict_area(i_pixel_value);
                pixels_sent++;
            end
            if (o_valid && i_ready) begin
                sums_checked++;
                if (area_expected.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("ERROR: unexpected result: area %0d eor %b eof %b",
                                 o_area_sum, o_end_of_row, o_end_of_frame);
                    end
                    mismatches++;
                end else begin
                    want = area_expected.pop_front();
                    if (want.eof) frames_seen++;
                    if (o_area_sum !== want.area || o_end_of_row !== want.eor ||
                        o_end_of_frame !== want.eof) begin
                        if (mismatches < 10) begin
                            $display("ERROR: result %0d: expected area %0d eor %b eof %b,",
                                     sums_checked, want.area, want.eor, want.eof);
                            $display("       got area %0d eor %b eof %b",
                                     o_area_sum, o_end_of_row, o_end_of_frame);
                        end
                        mismatches++;
                    end
                end
            end
        end
    end

    // Output side: random stalls, or a long hold-off when one is requested.
    initial begin : receiver
        int hold;
        forever begin
            @(posedge i_clk);
            if (ready_hold > 0) begin
                hold = ready_hold;
                ready_hold = 0;
                i_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Offer one pixel, possibly after a short gap, and wait for its transfer.
    task automatic send_pixel(logic [PIX_W-1:0] v);
        int gap;
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel_value <= v;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_run(int count, bit all_ones);
        for (int i = 0; i < count; i++) begin
            send_pixel(all_ones ? '1 : rand_pixel());
        end
    endtask

    // Stop offering and let every outstanding result come back.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (area_expected.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write both size registers; the block is idle whenever this is called.
    task automatic set_frame_size(logic [CFG_DATA_BITS-1:0] w, logic [CFG_DATA_BITS-1:0] h);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_FRAME_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        size_width = w;
        i_cfg_index <= REG_FRAME_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        size_height = h;
        i_cfg_valid <= 1'b0;
    endtask

    // A few pixels at the reset size, then a width below the current column,
    // so the next pixel closes its row at once.
    task automatic test_shrink_width();
        send_run(5, 1'b0);
        wait_idle();
        set_frame_size(11'd4, 11'd3);
        send_run(9, 1'b1);
        wait_idle();
    endtask

    // Zero sizes act as one: every pixel is its own row and frame.
    task automatic test_zero_sizes();
        set_frame_size(11'd0, 11'd0);
        send_pixel('0);
        send_pixel('1);
        send_pixel('1);
        wait_idle();
    endtask

    // A height below the current row closes the frame at the end of the row.
    task automatic test_shrink_height();
        set_frame_size(11'd2, 11'd4);
        send_run(4, 1'b0);
        wait_idle();
        set_frame_size(11'd2, 11'd1);
        send_run(2, 1'b0);
        wait_idle();
    endtask

    // Oversized registers saturate: one full-width row that closes its frame,
    // then a tall frame that must not close early.
    task automatic test_size_extremes();
        set_frame_size(11'd2047, 11'd1);
        send_run(MAX_W, 1'b1);
        wait_idle();
        set_frame_size(11'd1, 11'd2047);
        send_run(40, 1'b0);
        wait_idle();
    endtask

    // Hold the output off long enough for the block to stall its input.
    task automatic test_backpressure();
        idle_pct = 0;
        set_frame_size(11'd5, 11'd4);
        ready_hold = 300;
        send_run(80, 1'b0);
        wait_idle();
        idle_pct = 7;
    endtask

    // Random sizes, mostly whole frames, some cut short mid-frame.
    task automatic test_random_frames();
        int                       done;
        int                       frame;
        int                       count;
        logic [CFG_DATA_BITS-1:0] w;
        logic [CFG_DATA_BITS-1:0] h;
        done = 0;
        while (done < RANDOM_PIXELS) begin
            idle_pct = (done >= 200 && done < 450) ? 0 : 7;
            case ($urandom_range(99)) inside
                [0:69]:  w = CFG_DATA_BITS'($urandom_range(1, 8));
                [70:79]: w = CFG_DATA_BITS'($urandom_range(9, 40));
                [80:85]: w = '0;
                [86:92]: w = CFG_DATA_BITS'($urandom_range(MAX_W + 1, 2047));
                default: w = CFG_DATA_BITS'($urandom_range(41, MAX_W));
            endcase
            case ($urandom_range(99)) inside
                [0:69]:  h = CFG_DATA_BITS'($urandom_range(1, 6));
                [70:79]: h = '0;
                [80:89]: h = CFG_DATA_BITS'($urandom_range(7, 12));
                default: h = CFG_DATA_BITS'($urandom_range(13, 2047));
            endcase
            // Mid-frame, never widen past the columns the store has seen.
            if (row_at != '0 && effective_size(w, MAX_W) > columns_filled) begin
                w = CFG_DATA_BITS'(columns_filled);
            end
            set_frame_size(w, h);
            frame = effective_size(w, MAX_W) * effective_size(h, MAX_H);
            if (frame <= 120 && $urandom_range(99) < 85) begin
                count = frame * $urandom_range(1, 3);
            end else begin
                count = $urandom_range(1, (frame < 150) ? frame : 150);
            end
            send_run(count, 1'b0);
            done += count;
            wait_idle();
        end
        idle_pct = 7;
    endtask

    initial begin
        foreach (column_total[i]) column_total[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_shrink_width();
        test_zero_sizes();
        test_shrink_height();
        test_size_extremes();
        test_backpressure();
        test_random_frames();

        repeat (10) @(posedge i_clk);
        $display("testbench: %0d pixels sent, %0d sums checked, %0d frames closed",
                 pixels_sent, sums_checked, frames_seen);
        $display("testbench: rows up to %0d wide, zero and saturated sizes, mid-frame resizing, output stalls",
                 MAX_W);
        if (mismatches == 0 && area_expected.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
